>>> rtl/core/rrqg_pkg.sv
package rrqg_pkg;

  // longest rope, in particles
  localparam int MAX_SEGMENTS = 256;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_AMOUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE      = 3'd6;

  // q16.16 one in the field widths used
  localparam logic [16:0]        TEX_ONE  = 17'd65536;
  localparam logic signed [17:0] UNIT_ONE = 18'sd65536;
  localparam logic [30:0]        CFG_ONE  = 31'd65536;

  // quotient bits of the short (unit results, segment ratio) and long (unsegmented texture) divides
  localparam logic [5:0] DIV_SHORT = 6'd17;
  localparam logic [5:0] DIV_LONG  = 6'd48;

endpackage

>>> rtl/core/rope_ribbon_quad_generator.sv
// Rope ribbon quad generator. Rope particles come in one request at a time;
// start_req marks the first particle of a rope. Each later particle closes a
// segment and gives four camera-facing quad vertices (corners 0 and 1 at the
// previous particle, 2 and 3 at this one, last set on corner 3), each with
// position, texture u/v, normal and tangent, all Q16.16. A start particle, or
// a particle beyond the segment limit, is taken without a stall and gives no
// vertex. A segment gives its vertices one per cycle while vert_stall is low.
// The datapath has one shared 33x33 multiplier and one shared 66-bit
// subtract/compare used by a one-bit-per-cycle square root (32 steps, run
// twice) and a restoring divider (17 steps per unit vector component, 48
// steps for the unsegmented texture scale). Only one particle is in flight:
// pos_stall stays high from acceptance until corner 3 is taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, the block itself does not enforce this.
module rope_ribbon_quad_generator import rrqg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // particle requests
  input  logic                  pos_valid,
  output logic                  pos_stall,
  input  logic                  start_req,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  // vertex results
  output logic                  vert_valid,
  input  logic                  vert_stall,
  output logic signed [31:0]    vert_x,
  output logic signed [31:0]    vert_y,
  output logic signed [31:0]    vert_z,
  output logic [16:0]           tex_u,
  output logic signed [31:0]    tex_v,
  output logic signed [17:0]    normal_x,
  output logic signed [17:0]    normal_y,
  output logic signed [17:0]    normal_z,
  output logic signed [17:0]    tangent_x,
  output logic signed [17:0]    tangent_y,
  output logic signed [17:0]    tangent_z,
  output logic                  last,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [30:0]           cfg_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;   // sum of squared deltas
  localparam logic [3:0] S_LEN   = 4'd2;   // square root -> segment length
  localparam logic [3:0] S_DIVU  = 4'd3;   // up = delta / length
  localparam logic [3:0] S_CROSS = 4'd4;   // up x forward
  localparam logic [3:0] S_MAG   = 4'd5;   // sum of squared cross terms
  localparam logic [3:0] S_MAGRT = 4'd6;   // square root -> cross magnitude
  localparam logic [3:0] S_DIVR  = 4'd7;   // right = cross / magnitude
  localparam logic [3:0] S_NORM  = 4'd8;   // right x up
  localparam logic [3:0] S_OFS   = 4'd9;   // right * half width
  localparam logic [3:0] S_V0DIV = 4'd10;  // first segment texture divide
  localparam logic [3:0] S_V0MUL = 4'd11;  // segmented texture scale
  localparam logic [3:0] S_OUT   = 4'd12;  // hand out four corners

  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  // configuration
  logic signed [17:0] fwd_x, fwd_y, fwd_z;
  logic [30:0]        half_width, segment_length, tile_amount, tile_size;

  // control
  logic [3:0]       state;
  logic [5:0]       cnt;
  logic [1:0]       comp;
  logic [1:0]       corner;
  logic [CNT_W-1:0] particle_count;
  logic             first_seg;
  logic             v0_seg;

  // particle state
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic signed [31:0] cur_x, cur_y, cur_z;

  // segment datapath
  logic signed [31:0] d_x, d_y, d_z;
  logic [31:0]        len;
  logic signed [17:0] u_x, u_y, u_z;
  logic signed [26:0] c_x, c_y, c_z;
  logic [25:0]        mag;
  logic signed [17:0] r_x, r_y, r_z;
  logic signed [17:0] n_x, n_y, n_z;
  logic signed [32:0] o_x, o_y, o_z;
  logic signed [31:0] v0;
  logic [16:0]        ratio;

  // shared multiplier and accumulator
  logic signed [32:0] ma, mb;
  logic               msub;
  logic signed [65:0] prod, acc;
  logic [1:0]         nterms;
  logic [1:0]         term;
  logic               mac_done;

  // shared subtract/compare
  logic [65:0] sub_a, sub_b, sub_diff;
  logic        sub_ge;

  // square root
  logic [63:0] sv, sres, sbit;
  logic [63:0] sv_next, sres_next;
  logic [64:0] sq_trial;

  // divider
  logic [31:0] dr, dd, dr_next;
  logic [47:0] dn, dq, dq_next;
  logic [32:0] div_rr;
  logic [31:0] div_x;
  logic        div_neg;
  logic signed [17:0] div_res;
  logic        div_last;

  logic signed [31:0] base_x, base_y, base_z;
  logic               corner_pos;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] shr_tz(input logic signed [65:0] v, input int s);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    m = m >> s;
    return v[65] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [17:0] clamp_one(input logic signed [65:0] v);
    if (v > 66'sd65536) begin
      return UNIT_ONE;
    end else if (v < -66'sd65536) begin
      return -UNIT_ONE;
    end
    return v[17:0];
  endfunction

  assign pos_stall  = (state != S_IDLE);
  assign vert_valid = (state == S_OUT);

  // ---------------------------------------------------------------
  // multiplier operand selection
  // ---------------------------------------------------------------
  assign term = cnt[2:1];

  always_comb begin
    unique case (state)
      S_SQ, S_MAG: nterms = 2'd3;
      S_CROSS, S_NORM: nterms = 2'd2;
      default: nterms = 2'd1;
    endcase
  end

  assign mac_done = (cnt == {3'b000, nterms, 1'b0});

  always_comb begin
    ma   = '0;
    mb   = '0;
    msub = 1'b0;
    unique case (state)
      S_SQ: begin
        unique case (term)
          2'd0: begin ma = 33'(d_x); mb = 33'(d_x); end
          2'd1: begin ma = 33'(d_y); mb = 33'(d_y); end
          default: begin ma = 33'(d_z); mb = 33'(d_z); end
        endcase
      end
      S_MAG: begin
        unique case (term)
          2'd0: begin ma = 33'(c_x); mb = 33'(c_x); end
          2'd1: begin ma = 33'(c_y); mb = 33'(c_y); end
          default: begin ma = 33'(c_z); mb = 33'(c_z); end
        endcase
      end
      S_CROSS: begin
        msub = term[0];
        unique case ({comp, term[0]})
          3'b000: begin ma = 33'(u_y); mb = 33'(fwd_z); end
          3'b001: begin ma = 33'(u_z); mb = 33'(fwd_y); end
          3'b010: begin ma = 33'(u_z); mb = 33'(fwd_x); end
          3'b011: begin ma = 33'(u_x); mb = 33'(fwd_z); end
          3'b100: begin ma = 33'(u_x); mb = 33'(fwd_y); end
          default: begin ma = 33'(u_y); mb = 33'(fwd_x); end
        endcase
      end
      S_NORM: begin
        msub = term[0];
        unique case ({comp, term[0]})
          3'b000: begin ma = 33'(r_y); mb = 33'(u_z); end
          3'b001: begin ma = 33'(r_z); mb = 33'(u_y); end
          3'b010: begin ma = 33'(r_z); mb = 33'(u_x); end
          3'b011: begin ma = 33'(r_x); mb = 33'(u_z); end
          3'b100: begin ma = 33'(r_x); mb = 33'(u_y); end
          default: begin ma = 33'(r_y); mb = 33'(u_x); end
        endcase
      end
      S_OFS: begin
        mb = {2'b00, half_width};
        unique case (comp)
          2'd0: ma = 33'(r_x);
          2'd1: ma = 33'(r_y);
          default: ma = 33'(r_z);
        endcase
      end
      S_V0MUL: begin
        // (1 - ratio) * tile_amount
        ma = 33'd65536 - {16'd0, ratio};
        mb = {2'b00, tile_amount};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // shared subtract/compare: square root trial or divider step
  // ---------------------------------------------------------------
  assign sq_trial = {1'b0, sres} + {1'b0, sbit};
  assign div_rr   = {dr, dn[47]};

  always_comb begin
    if (state == S_LEN || state == S_MAGRT) begin
      sub_a = {2'b00, sv};
      sub_b = {1'b0, sq_trial};
    end else begin
      sub_a = {33'd0, div_rr};
      sub_b = {34'd0, dd};
    end
  end

  assign sub_diff = sub_a - sub_b;
  assign sub_ge   = ~sub_diff[65];

  assign sv_next   = sub_ge ? sub_diff[63:0] : sv;
  assign sres_next = sub_ge ? (sres >> 1) + sbit : (sres >> 1);

  assign dr_next = sub_ge ? sub_diff[31:0] : div_rr[31:0];
  assign dq_next = {dq[46:0], sub_ge};

  // dividend of the unit vector divides and the sign of the result
  always_comb begin
    logic signed [31:0] ds;
    logic signed [26:0] cs;
    logic signed [32:0] ce;
    unique case (comp)
      2'd0: begin ds = d_x; cs = c_x; end
      2'd1: begin ds = d_y; cs = c_y; end
      default: begin ds = d_z; cs = c_z; end
    endcase
    ce = 33'(cs);
    if (state == S_DIVR) begin
      div_neg = cs[26];
      div_x   = cs[26] ? 32'(-ce) : 32'(ce);
    end else begin
      div_neg = ds[31];
      div_x   = ds[31] ? 32'(-ds) : 32'(ds);
    end
  end

  assign div_res  = div_neg ? -$signed({1'b0, dq_next[16:0]}) : $signed({1'b0, dq_next[16:0]});
  assign div_last = (state == S_V0DIV && !v0_seg) ? (cnt == DIV_LONG) : (cnt == DIV_SHORT);

  // ---------------------------------------------------------------
  // sequencer and datapath registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      comp           <= '0;
      corner         <= '0;
      particle_count <= '0;
      first_seg      <= 1'b0;
      v0_seg         <= 1'b0;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_z         <= '0;
      fwd_x          <= '0;
      fwd_y          <= '0;
      fwd_z          <= UNIT_ONE;
      half_width     <= '0;
      segment_length <= '0;
      tile_amount    <= CFG_ONE;
      tile_size      <= CFG_ONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FORWARD_X:      fwd_x <= cfg_data[17:0];
          REG_FORWARD_Y:      fwd_y <= cfg_data[17:0];
          REG_FORWARD_Z:      fwd_z <= cfg_data[17:0];
          REG_HALF_WIDTH:     half_width <= cfg_data;
          REG_SEGMENT_LENGTH: segment_length <= cfg_data;
          REG_TILE_AMOUNT:    tile_amount <= cfg_data;
          REG_TILE_SIZE:      tile_size <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (pos_valid) begin
            if (start_req || particle_count == '0) begin
              // first particle of a rope only seeds the previous position
              prev_x         <= pos_x;
              prev_y         <= pos_y;
              prev_z         <= pos_z;
              particle_count <= CNT_W'(1);
            end else if (particle_count < CNT_W'(MAX_SEGMENTS)) begin
              particle_count <= particle_count + 1'b1;
              first_seg      <= (particle_count == CNT_W'(1));
              cur_x          <= pos_x;
              cur_y          <= pos_y;
              cur_z          <= pos_z;
              d_x            <= sat32(66'(pos_x) - 66'(prev_x));
              d_y            <= sat32(66'(pos_y) - 66'(prev_y));
              d_z            <= sat32(66'(pos_z) - 66'(prev_z));
              acc            <= '0;
              cnt            <= '0;
              comp           <= '0;
              state          <= S_SQ;
            end
          end
        end

        S_SQ, S_MAG, S_CROSS, S_NORM, S_OFS, S_V0MUL: begin
          if (!mac_done) begin
            cnt <= cnt + 1'b1;
            if (!cnt[0]) begin
              prod <= ma * mb;
            end else begin
              acc <= msub ? acc - prod : acc + prod;
            end
          end else begin
            acc <= '0;
            cnt <= '0;
            unique case (state)
              S_SQ: begin
                sv    <= acc[63:0];
                sres  <= '0;
                sbit  <= SQRT_BIT0;
                state <= S_LEN;
              end
              S_MAG: begin
                sv    <= acc[63:0];
                sres  <= '0;
                sbit  <= SQRT_BIT0;
                state <= S_MAGRT;
              end
              S_CROSS: begin
                unique case (comp)
                  2'd0: c_x <= 27'(shr_tz(acc, 8));
                  2'd1: c_y <= 27'(shr_tz(acc, 8));
                  default: c_z <= 27'(shr_tz(acc, 8));
                endcase
                comp <= (comp == 2'd2) ? 2'd0 : comp + 1'b1;
                if (comp == 2'd2) begin
                  state <= S_MAG;
                end
              end
              S_NORM: begin
                unique case (comp)
                  2'd0: n_x <= clamp_one(shr_tz(acc, 16));
                  2'd1: n_y <= clamp_one(shr_tz(acc, 16));
                  default: n_z <= clamp_one(shr_tz(acc, 16));
                endcase
                comp <= (comp == 2'd2) ? 2'd0 : comp + 1'b1;
                if (comp == 2'd2) begin
                  state <= S_OFS;
                end
              end
              S_OFS: begin
                unique case (comp)
                  2'd0: o_x <= 33'(shr_tz(acc, 16));
                  2'd1: o_y <= 33'(shr_tz(acc, 16));
                  default: o_z <= 33'(shr_tz(acc, 16));
                endcase
                comp <= (comp == 2'd2) ? 2'd0 : comp + 1'b1;
                if (comp == 2'd2) begin
                  dq <= '0;
                  priority if (first_seg && segment_length == '0) begin
                    // unsegmented first segment: len / tile_size
                    v0_seg <= 1'b0;
                    dr     <= '0;
                    dn     <= {len, 16'd0};
                    dd     <= (tile_size == '0) ? 32'd1 : {1'b0, tile_size};
                    cnt    <= 6'd1;
                    state  <= S_V0DIV;
                  end else if (first_seg && len < {1'b0, segment_length}) begin
                    // short first segment: len / segment_length
                    v0_seg <= 1'b1;
                    dr     <= {1'b0, len[31:1]};
                    dn     <= {len[0], 47'd0};
                    dd     <= {1'b0, segment_length};
                    cnt    <= 6'd1;
                    state  <= S_V0DIV;
                  end else begin
                    v0     <= {1'b0, tile_amount};
                    corner <= '0;
                    state  <= S_OUT;
                  end
                end
              end
              default: begin
                // texture scale of a short first segment
                v0     <= $signed({1'b0, tile_amount} - {1'b0, acc[46:16]});
                corner <= '0;
                state  <= S_OUT;
              end
            endcase
          end
        end

        S_LEN, S_MAGRT: begin
          sv   <= sv_next;
          sres <= sres_next;
          sbit <= sbit >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd31) begin
            cnt  <= '0;
            comp <= '0;
            if (state == S_LEN) begin
              len   <= sres_next[31:0];
              state <= S_DIVU;
            end else begin
              mag   <= sres_next[25:0];
              state <= S_DIVR;
            end
          end
        end

        S_DIVU, S_DIVR: begin
          logic [31:0] dvs;
          logic        zero_div;
          dvs      = (state == S_DIVU) ? len : {6'd0, mag};
          zero_div = (dvs == '0);
          if (cnt == '0 && !zero_div) begin
            dr  <= {1'b0, div_x[31:1]};
            dn  <= {div_x[0], 47'd0};
            dd  <= dvs;
            dq  <= '0;
            cnt <= 6'd1;
          end else if (cnt == '0 || div_last) begin
            // zero length or degenerate cross gives a zero component
            unique case ({state == S_DIVR, comp})
              3'b000: u_x <= zero_div ? '0 : div_res;
              3'b001: u_y <= zero_div ? '0 : div_res;
              3'b010: u_z <= zero_div ? '0 : div_res;
              3'b100: r_x <= zero_div ? '0 : div_res;
              3'b101: r_y <= zero_div ? '0 : div_res;
              default: r_z <= zero_div ? '0 : div_res;
            endcase
            cnt  <= '0;
            comp <= (comp == 2'd2) ? 2'd0 : comp + 1'b1;
            if (comp == 2'd2) begin
              acc   <= '0;
              state <= (state == S_DIVU) ? S_CROSS : S_NORM;
            end
          end else begin
            dr  <= dr_next;
            dq  <= dq_next;
            dn  <= dn << 1;
            cnt <= cnt + 1'b1;
          end
        end

        S_V0DIV: begin
          dr  <= dr_next;
          dq  <= dq_next;
          dn  <= dn << 1;
          cnt <= cnt + 1'b1;
          if (div_last) begin
            cnt <= '0;
            if (v0_seg) begin
              ratio <= dq_next[16:0];
              acc   <= '0;
              state <= S_V0MUL;
            end else begin
              v0     <= sat32($signed({35'd0, tile_amount}) - 66'sd65536
                              + $signed({18'd0, dq_next}));
              corner <= '0;
              state  <= S_OUT;
            end
          end
        end

        S_OUT: begin
          if (!vert_stall) begin
            corner <= corner + 1'b1;
            if (corner == 2'd3) begin
              prev_x <= cur_x;
              prev_y <= cur_y;
              prev_z <= cur_z;
              state  <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // corner outputs: 0,1 at the previous particle, 2,3 at this one
  // ---------------------------------------------------------------
  assign corner_pos = (corner == 2'd0) || (corner == 2'd3);
  assign base_x     = corner[1] ? cur_x : prev_x;
  assign base_y     = corner[1] ? cur_y : prev_y;
  assign base_z     = corner[1] ? cur_z : prev_z;

  assign vert_x = corner_pos ? sat32(66'(base_x) + 66'(o_x)) : sat32(66'(base_x) - 66'(o_x));
  assign vert_y = corner_pos ? sat32(66'(base_y) + 66'(o_y)) : sat32(66'(base_y) - 66'(o_y));
  assign vert_z = corner_pos ? sat32(66'(base_z) + 66'(o_z)) : sat32(66'(base_z) - 66'(o_z));

  assign tex_u     = corner_pos ? TEX_ONE : '0;
  assign tex_v     = corner[1] ? '0 : v0;
  assign normal_x  = n_x;
  assign normal_y  = n_y;
  assign normal_z  = n_z;
  assign tangent_x = r_x;
  assign tangent_y = r_y;
  assign tangent_z = r_z;
  assign last      = (corner == 2'd3);

endmodule

>>> rtl/core/rrqg_chk.sv
module rrqg_chk import rrqg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 pos_stall,
  input logic                 vert_valid,
  input logic                 vert_stall,
  input logic signed [31:0]   vert_x,
  input logic [16:0]          tex_u,
  input logic signed [31:0]   tex_v,
  input logic                 last
);

  // a stalled vertex holds
  assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert_stall |=> vert_valid && $stable(vert_x) && $stable(tex_v)
                                 && $stable(last))
    else $error("stalled vertex changed");

  // no new particle while vertices are pending
  assert property (@(posedge clk) disable iff (rst)
    vert_valid |-> pos_stall)
    else $error("particle taken while vertices pending");

  // a quad runs its four corners without a gap
  assert property (@(posedge clk) disable iff (rst)
    vert_valid && !vert_stall && !last |=> vert_valid)
    else $error("quad broken off before its last corner");

  // the quad ends on its last corner
  assert property (@(posedge clk) disable iff (rst)
    vert_valid && !vert_stall && last |=> !vert_valid)
    else $error("vertex after the last corner");

  // u is either one or zero on every vertex
  assert property (@(posedge clk) disable iff (rst)
    vert_valid |-> (tex_u == TEX_ONE) || (tex_u == 17'd0))
    else $error("bad texture u");

endmodule

bind rope_ribbon_quad_generator rrqg_chk u_rrqg_chk (.*);

>>> verif/rrqg_checker.sv
`timescale 1ns / 1ps

module rrqg_checker import rrqg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pos_valid,
  input  logic                  pos_stall,
  input  logic                  start_req,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic                  vert_valid,
  input  logic                  vert_stall,
  input  logic signed [31:0]    vert_x,
  input  logic signed [31:0]    vert_y,
  input  logic signed [31:0]    vert_z,
  input  logic [16:0]           tex_u,
  input  logic signed [31:0]    tex_v,
  input  logic signed [17:0]    normal_x,
  input  logic signed [17:0]    normal_y,
  input  logic signed [17:0]    normal_z,
  input  logic signed [17:0]    tangent_x,
  input  logic signed [17:0]    tangent_y,
  input  logic signed [17:0]    tangent_z,
  input  logic                  last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [30:0]           cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic [16:0]        u;
    logic signed [31:0] v;
    logic signed [17:0] nx, ny, nz, tx, ty, tz;
    logic               lst;
  } vertex_t;

  vertex_t vertex_q[$];

  longint fwd_x, fwd_y, fwd_z, half_w, seg_len, tile_amt, tile_sz;
  longint last_x, last_y, last_z;
  int     rope_count;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // arithmetic shift that rounds toward zero
  function automatic longint shr_zero(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // segment quad prediction
  task automatic predict_quad(longint px, longint py, longint pz);
    longint dx, dy, dz, ux, uy, uz, rx, ry, rz, cx, cy, cz, nx, ny, nz;
    longint ox, oy, oz, v0, len, mag, ts, r, bx, by, bz, s;
    vertex_t vt;
    ux = 0; uy = 0; uz = 0; rx = 0; ry = 0; rz = 0;
    dx = sat32(px - last_x);
    dy = sat32(py - last_y);
    dz = sat32(pz - last_z);
    len = root64(longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz));
    if (len != 0) begin
      ux = clamp_unit((dx * 65536) / len);
      uy = clamp_unit((dy * 65536) / len);
      uz = clamp_unit((dz * 65536) / len);
    end
    cx = shr_zero(uy * fwd_z - uz * fwd_y, 8);
    cy = shr_zero(uz * fwd_x - ux * fwd_z, 8);
    cz = shr_zero(ux * fwd_y - uy * fwd_x, 8);
    mag = root64(cx * cx + cy * cy + cz * cz);
    if (mag != 0) begin
      rx = clamp_unit((cx * 65536) / mag);
      ry = clamp_unit((cy * 65536) / mag);
      rz = clamp_unit((cz * 65536) / mag);
    end
    nx = clamp_unit(shr_zero(ry * uz - rz * uy, 16));
    ny = clamp_unit(shr_zero(rz * ux - rx * uz, 16));
    nz = clamp_unit(shr_zero(rx * uy - ry * ux, 16));
    ox = shr_zero(rx * half_w, 16);
    oy = shr_zero(ry * half_w, 16);
    oz = shr_zero(rz * half_w, 16);
    v0 = tile_amt;
    // first segment of a rope gets a v scaled by its length when unsegmented or shorter than the segment length
    if (rope_count == 2) begin
      if (seg_len == 0) begin
        ts = (tile_sz != 0) ? tile_sz : 1;
        v0 = tile_amt - 65536 + (len * 65536) / ts;
      end else if (len < seg_len) begin
        r = (len * 65536) / seg_len;
        v0 = tile_amt - shr_zero((65536 - r) * tile_amt, 16);
      end
    end
    v0 = sat32(v0);
    for (int k = 0; k < 4; k++) begin
      bx = (k < 2) ? last_x : px;
      by = (k < 2) ? last_y : py;
      bz = (k < 2) ? last_z : pz;
      s = (k == 0 || k == 3) ? 1 : -1;
      vt.x = sat32(bx + s * ox);
      vt.y = sat32(by + s * oy);
      vt.z = sat32(bz + s * oz);
      vt.u = (k == 0 || k == 3) ? TEX_ONE : '0;
      vt.v = (k < 2) ? v0 : 0;
      vt.nx = nx; vt.ny = ny; vt.nz = nz;
      vt.tx = rx; vt.ty = ry; vt.tz = rz;
      vt.lst = (k == 3);
      vertex_q.push_back(vt);
    end
  endtask

  task automatic report(string what, longint e, longint a);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0d actual %0d", what, e, a);
  endtask

  assign pending = vertex_q.size();

  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      fwd_x <= 0; fwd_y <= 0; fwd_z <= 65536;
      half_w <= 0; seg_len <= 0; tile_amt <= 65536; tile_sz <= 65536;
      last_x <= 0; last_y <= 0; last_z <= 0;
      rope_count = 0;
      errors = 0;
      vertex_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FORWARD_X:      fwd_x <= longint'($signed(cfg_data[17:0]));
          REG_FORWARD_Y:      fwd_y <= longint'($signed(cfg_data[17:0]));
          REG_FORWARD_Z:      fwd_z <= longint'($signed(cfg_data[17:0]));
          REG_HALF_WIDTH:     half_w <= longint'(cfg_data);
          REG_SEGMENT_LENGTH: seg_len <= longint'(cfg_data);
          REG_TILE_AMOUNT:    tile_amt <= longint'(cfg_data);
          REG_TILE_SIZE:      tile_sz <= longint'(cfg_data);
          default: ;
        endcase
      end
      if (pos_valid && !pos_stall) begin
        if (start_req || rope_count == 0) begin
          rope_count = 1;
          last_x <= pos_x; last_y <= pos_y; last_z <= pos_z;
        end else if (rope_count < MAX_SEGMENTS) begin
          rope_count++;
          predict_quad(pos_x, pos_y, pos_z);
          last_x <= pos_x; last_y <= pos_y; last_z <= pos_z;
        end
      end
      if (vert_valid && !vert_stall) begin
        if (vertex_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected vertex");
        end else begin
          e = vertex_q.pop_front();
          if (e.x != vert_x) report("vert_x", e.x, vert_x);
          if (e.y != vert_y) report("vert_y", e.y, vert_y);
          if (e.z != vert_z) report("vert_z", e.z, vert_z);
          if (e.u != tex_u) report("tex_u", e.u, tex_u);
          if (e.v != tex_v) report("tex_v", e.v, tex_v);
          if (e.nx != normal_x) report("normal_x", e.nx, normal_x);
          if (e.ny != normal_y) report("normal_y", e.ny, normal_y);
          if (e.nz != normal_z) report("normal_z", e.nz, normal_z);
          if (e.tx != tangent_x) report("tangent_x", e.tx, tangent_x);
          if (e.ty != tangent_y) report("tangent_y", e.ty, tangent_y);
          if (e.tz != tangent_z) report("tangent_z", e.tz, tangent_z);
          if (e.lst != last) report("last", e.lst, last);
        end
      end
    end
  end

endmodule

>>> verif/tb_rope_ribbon_quad_generator.sv
`timescale 1ns / 1ps

module tb_rope_ribbon_quad_generator;
  import rrqg_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pos_valid = 1'b0, start_req = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic vert_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FORWARD_X;
  logic [30:0] cfg_data = '0;

  logic pos_stall, vert_valid, last;
  logic signed [31:0] vert_x, vert_y, vert_z, tex_v;
  logic [16:0] tex_u;
  logic signed [17:0] normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z;

  int errors, pending;
  int cycles = 0;
  bit hold_off = 1'b0;   // long receiver hold-off request

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rope_ribbon_quad_generator dut (.*);

  rrqg_checker chk (.*);

  // run limit, far past the slowest run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall pattern: phases of no stall, light and heavy stalling
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 1500) % 3;
    if (hold_off) vert_stall <= 1'b1;
    else if (mode == 0) vert_stall <= 1'b0;
    else if (mode == 1) vert_stall <= ($urandom_range(0, 3) == 0);
    else vert_stall <= ($urandom_range(0, 3) != 0);
  end

  // drive one particle request and wait for its acceptance
  task automatic send_particle(bit st, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pos_valid <= 1'b1;
    start_req <= st;
    pos_x <= x; pos_y <= y; pos_z <= z;
    do @(posedge clk); while (pos_stall);
  endtask

  // drop valid, then a random gap now and then
  task automatic gap;
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
    if (n > 0) begin
      pos_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    pos_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one write, with cfg_we dropped again before the next
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [30:0] rand_unit18;
    int v;
    v = $urandom_range(0, 131072) - 65536;
    return 31'(v) & 31'h3FFFF;
  endfunction

  // mostly small coordinates, sometimes anything
  function automatic logic [31:0] rand_coord(logic [31:0] base);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return base;
      default: return base + $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
    endcase
  endfunction

  task automatic random_config;
    write_reg(REG_FORWARD_X, rand_unit18());
    write_reg(REG_FORWARD_Y, rand_unit18());
    write_reg(REG_FORWARD_Z, rand_unit18());
    write_reg(REG_HALF_WIDTH, ($urandom_range(0, 4) == 0) ? 31'($urandom) :
                              31'($urandom_range(0, 400000)));
    write_reg(REG_SEGMENT_LENGTH, ($urandom_range(0, 2) == 0) ? '0 :
                                  31'($urandom_range(1, 3000000)));
    write_reg(REG_TILE_AMOUNT, ($urandom_range(0, 4) == 0) ? 31'($urandom) :
                               31'($urandom_range(0, 300000)));
    write_reg(REG_TILE_SIZE, ($urandom_range(0, 4) == 0) ? 31'($urandom) :
                             31'($urandom_range(0, 300000)));
  endtask

  initial begin
    logic [31:0] x, y, z;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no start since reset: the first particle acts as a start
    send_particle(1'b0, 32'sd0, 32'sd0, 32'sd0);
    send_particle(1'b0, 32'sd65536, 32'sd0, 32'sd0);
    // zero length segment
    send_particle(1'b0, 32'sd65536, 32'sd0, 32'sd0);
    // segment along forward: degenerate cross
    send_particle(1'b0, 32'sd65536, 32'sd0, 32'sd200000);
    drain();

    // extreme registers
    write_reg(REG_FORWARD_X, 31'h3FFFF & 31'(-65536));
    write_reg(REG_FORWARD_Y, 31'd65536);
    write_reg(REG_FORWARD_Z, '0);
    write_reg(REG_HALF_WIDTH, 31'h7FFFFFFF);
    write_reg(REG_SEGMENT_LENGTH, 31'h7FFFFFFF);
    write_reg(REG_TILE_AMOUNT, 31'h7FFFFFFF);
    write_reg(REG_TILE_SIZE, '0);
    // huge segments saturate delta
    send_particle(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_particle(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_particle(1'b0, 32'hFFFFFFFF, 32'h00000001, 32'h0);
    send_particle(1'b1, 32'h0, 32'h0, 32'h0);
    send_particle(1'b0, 32'sd1000, 32'sd3, 32'sd0);
    drain();

    write_reg(REG_SEGMENT_LENGTH, 31'd1);
    write_reg(REG_TILE_SIZE, 31'h7FFFFFFF);
    write_reg(REG_HALF_WIDTH, '0);
    write_reg(REG_TILE_AMOUNT, '0);
    send_particle(1'b1, 32'sd5, 32'sd5, 32'sd5);
    send_particle(1'b0, 32'sd70000, 32'sd1, 32'sd90000);
    drain();

    // a full rope past the segment limit, with small segments
    write_reg(REG_TILE_AMOUNT, 31'd65536);
    send_particle(1'b1, 32'sd0, 32'sd0, 32'sd0);
    x = 0;
    for (int i = 0; i < MAX_SEGMENTS + 3; i++) begin
      x = x + 32'sd30000;
      send_particle(1'b0, x, 32'($urandom_range(0, 5000)), 32'($urandom_range(0, 5000)));
    end
    drain();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_particle(1'b1, 32'sd0, 32'sd0, 32'sd0);
        for (int i = 0; i < 4; i++)
          send_particle(1'b0, rand_coord(32'sd0), rand_coord(32'sd0), rand_coord(32'sd0));
      end
    join
    drain();

    // random ropes under several settings
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      x = $urandom; y = $urandom; z = $urandom;
      for (int i = 0; i < 14; i++) begin
        // a start now and then begins a short rope of varied length
        send_particle(($urandom_range(0, 3) == 0), x, y, z);
        gap();
        x = rand_coord(x); y = rand_coord(y); z = rand_coord(z);
        if ($urandom_range(0, 5) == 0) begin
          send_particle(1'b1, x, y, z);
          gap();
        end
      end
      drain();
    end

    // final settle
    pos_valid <= 1'b0;
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
